// ----- rtl/ertt_pkg.sv -----
// Shared types and constants for the echo request round-trip tracker.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package ertt_pkg;

    localparam int TABLE_DEPTH = 64;

    localparam logic [7:0]  MS_PER_TICK_RESET = 8'd10;
    localparam logic [15:0] AUTO_ID_RESET     = 16'd1;
    localparam logic [15:0] AUTO_SEQ          = 16'd1;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_AUTO     = 2'd1,
        OP_REPLY    = 2'd2,
        OP_UNUSED   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_REGISTERED = 2'd0,
        ST_FULL       = 2'd1,
        ST_MATCHED    = 2'd2,
        ST_UNMATCHED  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMPARE,
        S_PICK,
        S_REDUCE,
        S_SCALE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] request_id;
        logic [15:0] sequence_req;
        logic [31:0] peer_addr;
        logic        wants_notify;
        logic [31:0] tick_now;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] used_id;
        logic [15:0] used_seq;
        logic [31:0] round_trip;
        logic        notify;
    } result_t;

    // Broadcast from the sequencer to every cell of the table.
    typedef struct packed {
        logic        compare;
        logic        pick;
        logic        is_reg;
        logic [15:0] ident;
        logic [15:0] seqno;
        logic [31:0] peer;
        logic [31:0] start_tick;
        logic        notify;
    } cell_cmd_t;

    // What a cell hands back after a pick: its tick and flag if it matched, else zero.
    typedef struct packed {
        logic [31:0] sel_tick;
        logic        sel_notify;
    } cell_sel_t;

endpackage

`default_nettype wire

// ----- rtl/ertt_cell.sv -----
// One table entry of the round-trip tracker: stores a request, compares it
// against the broadcast item and passes the found token to its upper neighbor.
// Depends on ertt_pkg.
`default_nettype none

module ertt_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ertt_pkg::cell_cmd_t cmd,
    input  wire logic               found_in,
    output logic                    found_out,
    output logic                    take,
    output ertt_pkg::cell_sel_t     sel
);

    logic        valid_reg;
    logic        hit_reg;
    logic [15:0] ident_reg;
    logic [15:0] seqno_reg;
    logic [31:0] peer_reg;
    logic [31:0] tick_reg;
    logic        notify_reg;
    logic [31:0] sel_tick_reg;
    logic        sel_notify_reg;
    logic        hit_next;

    always_comb
    begin
        if (cmd.is_reg)
        begin
            hit_next = !valid_reg;
        end
        else
        begin
            hit_next = valid_reg && (ident_reg == cmd.ident) &&
                       (seqno_reg == cmd.seqno) && (peer_reg == cmd.peer);
        end
    end

    // Lowest hit wins: pass the token upward once any cell below has hit.
    assign take      = hit_reg && !found_in;
    assign found_out = found_in || hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            sel_tick_reg   <= '0;
            sel_notify_reg <= 1'b0;
        end
        else
        begin
            if (cmd.compare)
            begin
                hit_reg <= hit_next;
            end
            if (cmd.pick)
            begin
                if (take)
                begin
                    valid_reg <= cmd.is_reg;
                end
                sel_tick_reg   <= (take && !cmd.is_reg) ? tick_reg : '0;
                sel_notify_reg <= take && !cmd.is_reg && notify_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pick && take && cmd.is_reg)
        begin
            ident_reg  <= cmd.ident;
            seqno_reg  <= cmd.seqno;
            peer_reg   <= cmd.peer;
            tick_reg   <= cmd.start_tick;
            notify_reg <= cmd.notify;
        end
    end

    assign sel.sel_tick   = sel_tick_reg;
    assign sel.sel_notify = sel_notify_reg;

endmodule

`default_nettype wire

// ----- rtl/ertt_table.sv -----
// Row of tracker cells linked by the found token, plus the OR merge of
// the picked entry's tick and notify flag. Depends on ertt_pkg, ertt_cell.
`default_nettype none

module ertt_table (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ertt_pkg::cell_cmd_t         cmd,
    output logic                             found,
    output logic [ertt_pkg::TABLE_DEPTH-1:0] take_vec,
    output ertt_pkg::cell_sel_t              sel
);

    logic [ertt_pkg::TABLE_DEPTH:0]   chain;
    ertt_pkg::cell_sel_t              cell_sel [ertt_pkg::TABLE_DEPTH];

    assign chain[0] = 1'b0;

    for (genvar i = 0; i < ertt_pkg::TABLE_DEPTH; i++)
    begin : g_cell
        ertt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .found_in  (chain[i]),
            .found_out (chain[i+1]),
            .take      (take_vec[i]),
            .sel       (cell_sel[i])
        );
    end

    assign found = chain[ertt_pkg::TABLE_DEPTH];

    // At most one cell holds a nonzero selection, so OR merges them.
    always_comb
    begin
        sel = '0;
        for (int i = 0; i < ertt_pkg::TABLE_DEPTH; i++)
        begin
            sel = sel | cell_sel[i];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/echo_request_rtt_tracker.sv -----
// Echo request round-trip tracker: table of outstanding requests as a row of cells.
// Each item passes the compare, pick (found token ripple), merge and scale steps in turn;
// a new item is taken only once the previous one has left the emit step.
// A waiting result does not block the next input transfer (separate output register).
// Reset (rst_n, async, active low): table empty, auto id 1, ms_per_tick 10.
// Depends on ertt_pkg, ertt_table, ertt_cell.
`default_nettype none

module echo_request_rtt_tracker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire ertt_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output ertt_pkg::result_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data
);

    ertt_pkg::state_t   state_reg;
    ertt_pkg::state_t   state_next;
    ertt_pkg::item_t    item_reg;
    ertt_pkg::item_t    item_next;
    logic [15:0]        auto_id_reg;
    logic [7:0]         ms_per_tick_reg;
    logic               found_reg;
    logic               notify_sel_reg;
    logic [31:0]        diff_reg;
    logic [31:0]        rtt_reg;
    logic [31:0]        prod_full;
    ertt_pkg::result_t  result_reg;
    ertt_pkg::result_t  result_next;
    logic               result_valid_reg;

    logic                             item_xfer;
    logic                             is_reg_op;
    logic                             emit_load;
    logic                             compare_en;
    logic                             pick_en;
    ertt_pkg::cell_cmd_t              cmd;
    logic                             table_found;
    logic [ertt_pkg::TABLE_DEPTH-1:0] take_vec;
    ertt_pkg::cell_sel_t              table_sel;

    // ------------------------------------------------------------------
    // Configuration: always ready; write only while no item is in flight.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_per_tick_reg <= ertt_pkg::MS_PER_TICK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ms_per_tick_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Input capture. An auto register takes the counter as identifier and
    // a fixed sequence; the counter advances whether or not the table has room.
    // ------------------------------------------------------------------
    assign item_xfer = item_valid && item_ready;
    assign is_reg_op = (item_reg.opcode == ertt_pkg::OP_REGISTER) ||
                       (item_reg.opcode == ertt_pkg::OP_AUTO);

    always_comb
    begin
        item_next = item;
        if (item.opcode == ertt_pkg::OP_AUTO)
        begin
            item_next.request_id   = auto_id_reg;
            item_next.sequence_req = ertt_pkg::AUTO_SEQ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_id_reg <= ertt_pkg::AUTO_ID_RESET;
        end
        else if (item_xfer && (item.opcode == ertt_pkg::OP_AUTO))
        begin
            auto_id_reg <= auto_id_reg + 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            item_reg <= item_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ertt_pkg::S_IDLE:
            begin
                // Drop unused opcodes: no result, no state change.
                if (item_xfer && (item.opcode != ertt_pkg::OP_UNUSED))
                begin
                    state_next = ertt_pkg::S_COMPARE;
                end
            end
            ertt_pkg::S_COMPARE: state_next = ertt_pkg::S_PICK;
            ertt_pkg::S_PICK:    state_next = ertt_pkg::S_REDUCE;
            ertt_pkg::S_REDUCE:  state_next = ertt_pkg::S_SCALE;
            ertt_pkg::S_SCALE:   state_next = ertt_pkg::S_EMIT;
            ertt_pkg::S_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = ertt_pkg::S_IDLE;
                end
            end
            default:             state_next = ertt_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs.
    // ------------------------------------------------------------------
    always_comb
    begin
        item_ready = 1'b0;
        compare_en = 1'b0;
        pick_en    = 1'b0;
        emit_load  = 1'b0;
        unique case (state_reg)
            ertt_pkg::S_IDLE:    item_ready = 1'b1;
            ertt_pkg::S_COMPARE: compare_en = 1'b1;
            ertt_pkg::S_PICK:    pick_en    = 1'b1;
            ertt_pkg::S_REDUCE:  ;
            ertt_pkg::S_SCALE:   ;
            // Hold the finished result until the output register frees up.
            ertt_pkg::S_EMIT:    emit_load  = !result_valid_reg || result_ready;
            default:             ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ertt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Broadcast the captured item to all cells.
    always_comb
    begin
        cmd.compare    = compare_en;
        cmd.pick       = pick_en;
        cmd.is_reg     = is_reg_op;
        cmd.ident      = item_reg.request_id;
        cmd.seqno      = item_reg.sequence_req;
        cmd.peer       = item_reg.peer_addr;
        cmd.start_tick = item_reg.tick_now;
        cmd.notify     = item_reg.wants_notify;
    end

    ertt_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .found    (table_found),
        .take_vec (take_vec),
        .sel      (table_sel)
    );

    // ------------------------------------------------------------------
    // Round trip: latch found after pick, subtract after merge, then scale.
    // The product keeps only its low 32 bits, so it wraps like the difference.
    // ------------------------------------------------------------------
    assign prod_full = diff_reg * {24'd0, ms_per_tick_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == ertt_pkg::S_PICK)
        begin
            found_reg <= table_found;
        end
        if (state_reg == ertt_pkg::S_REDUCE)
        begin
            diff_reg       <= item_reg.tick_now - table_sel.sel_tick;
            notify_sel_reg <= table_sel.sel_notify;
        end
        if (state_reg == ertt_pkg::S_SCALE)
        begin
            rtt_reg <= prod_full;
        end
    end

    // ------------------------------------------------------------------
    // Result formatting and output register.
    // ------------------------------------------------------------------
    always_comb
    begin
        result_next.used_id    = item_reg.request_id;
        result_next.used_seq   = item_reg.sequence_req;
        result_next.round_trip = '0;
        result_next.notify     = 1'b0;
        if (is_reg_op)
        begin
            result_next.status = found_reg ? ertt_pkg::ST_REGISTERED : ertt_pkg::ST_FULL;
        end
        else if (found_reg)
        begin
            result_next.status     = ertt_pkg::ST_MATCHED;
            result_next.round_trip = rtt_reg;
            result_next.notify     = notify_sel_reg;
        end
        else
        begin
            result_next.status = ertt_pkg::ST_UNMATCHED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_single_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ertt_pkg::S_PICK) |-> $onehot0(take_vec))
        else $error("more than one cell took the item");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ertt_pkg::S_EMIT))
        else $error("result appeared outside the emit step");

    a_auto_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && (item.opcode == ertt_pkg::OP_AUTO))
            |=> (auto_id_reg == $past(auto_id_reg) + 16'd1))
        else $error("auto id counter did not advance");

    a_reg_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && ((result_reg.status == ertt_pkg::ST_REGISTERED) ||
                              (result_reg.status == ertt_pkg::ST_FULL)))
            |-> ((result_reg.round_trip == 32'd0) && !result_reg.notify))
        else $error("register result carries round trip or notify");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for echo_request_rtt_tracker: stimulus, idle and stall patterns,
// a round-trip predictor and a checker. Depends on ertt_pkg and the tracker RTL.

module tb_top;

    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off that backs up the tracker
    localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer at all before giving up
    localparam int SETTLE_CYCLES = 8;     // extra wait after the last expected result
    localparam int RESET_CYCLES  = 5;

    // How a directed row is checked: against the predictor, against a typed-in
    // result, or as a row that must produce nothing at all.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_TYPED,
        CHK_SILENT
    } row_check_t;

    typedef struct packed {
        row_check_t          mode;
        ertt_pkg::item_t     stim;
        ertt_pkg::result_t   want;
    } stim_row_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    ertt_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    ertt_pkg::result_t result;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_data     = 8'd0;

    // Idle percentages per side, and the one-shot request for the long hold-off.
    int          tx_idle_pct  = 6;
    int          rx_idle_pct  = 45;
    logic        hold_req     = 1'b0;
    int          hold_left    = 0;
    logic        hold_done    = 1'b0;

    int          fail_count   = 0;
    int          quiet_cycles = 0;

    // Predictor state: the request table, the auto id counter and the tick scale.
    logic        live        [ertt_pkg::TABLE_DEPTH];
    logic [15:0] live_id     [ertt_pkg::TABLE_DEPTH];
    logic [15:0] live_seqno  [ertt_pkg::TABLE_DEPTH];
    logic [31:0] live_peer   [ertt_pkg::TABLE_DEPTH];
    logic [31:0] live_tick   [ertt_pkg::TABLE_DEPTH];
    logic        live_notify [ertt_pkg::TABLE_DEPTH];
    logic [15:0] next_auto_id = 16'd1;
    logic [7:0]  scale_ms     = 8'd10;
    logic [31:0] wall_tick    = 32'd0;

    ertt_pkg::result_t pending_results [$];
    stim_row_t         directed_rows   [$];

    echo_request_rtt_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Apply one item to the predicted table; return 1 and the result if the
    // item produces one. Registers take the lowest free slot, replies free the
    // lowest live slot whose id, sequence and peer all agree.
    function automatic logic predict_echo(input ertt_pkg::item_t it,
                                          output ertt_pkg::result_t res);
        logic [15:0] id_v;
        logic [15:0] seq_v;
        logic [31:0] span;
        res   = '0;
        id_v  = it.request_id;
        seq_v = it.sequence_req;
        case (it.opcode)
            ertt_pkg::OP_REGISTER, ertt_pkg::OP_AUTO:
            begin
                if (it.opcode == ertt_pkg::OP_AUTO)
                begin
                    // Auto ids come from the counter, which wraps through zero.
                    id_v         = next_auto_id;
                    seq_v        = 16'd1;
                    next_auto_id = next_auto_id + 16'd1;
                end
                res.used_id  = id_v;
                res.used_seq = seq_v;
                res.status   = ertt_pkg::ST_FULL;
                for (int i = 0; i < ertt_pkg::TABLE_DEPTH; i++)
                begin
                    if (!live[i])
                    begin
                        live[i]        = 1'b1;
                        live_id[i]     = id_v;
                        live_seqno[i]  = seq_v;
                        live_peer[i]   = it.peer_addr;
                        live_tick[i]   = it.tick_now;
                        live_notify[i] = it.wants_notify;
                        res.status     = ertt_pkg::ST_REGISTERED;
                        break;
                    end
                end
                return 1'b1;
            end
            ertt_pkg::OP_REPLY:
            begin
                res.used_id  = id_v;
                res.used_seq = seq_v;
                res.status   = ertt_pkg::ST_UNMATCHED;
                for (int i = 0; i < ertt_pkg::TABLE_DEPTH; i++)
                begin
                    if (live[i] && live_id[i] == id_v && live_seqno[i] == seq_v &&
                        live_peer[i] == it.peer_addr)
                    begin
                        live[i]        = 1'b0;
                        // Both the tick difference and the product wrap at 32 bits.
                        span           = it.tick_now - live_tick[i];
                        res.round_trip = span * scale_ms;
                        res.notify     = live_notify[i];
                        res.status     = ertt_pkg::ST_MATCHED;
                        break;
                    end
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic ertt_pkg::item_t mk_item(input ertt_pkg::opcode_t op,
                                                input logic [15:0] id,
                                                input logic [15:0] seqno,
                                                input logic [31:0] peer,
                                                input logic nfy, input logic [31:0] tick);
        ertt_pkg::item_t it;
        it.opcode       = op;
        it.request_id   = id;
        it.sequence_req = seqno;
        it.peer_addr    = peer;
        it.wants_notify = nfy;
        it.tick_now     = tick;
        return it;
    endfunction

    function automatic ertt_pkg::result_t mk_result(input ertt_pkg::status_t st,
                                                    input logic [15:0] id,
                                                    input logic [15:0] seqno,
                                                    input logic [31:0] rtt,
                                                    input logic nfy);
        ertt_pkg::result_t r;
        r.status     = st;
        r.used_id    = id;
        r.used_seq   = seqno;
        r.round_trip = rtt;
        r.notify     = nfy;
        return r;
    endfunction

    function automatic void add_row(input row_check_t mode, input ertt_pkg::item_t stim,
                                    input ertt_pkg::result_t want);
        stim_row_t row;
        row.mode = mode;
        row.stim = stim;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    // Mostly creep forward like a real tick counter; now and then jump anywhere,
    // so that differences wrap and every tick bit toggles.
    function automatic void advance_tick();
        if ($urandom_range(19) == 0)
            wall_tick = $urandom;
        else
            wall_tick = wall_tick + $urandom_range(40);
    endfunction

    function automatic int pick_live_slot();
        int slots [$];
        for (int i = 0; i < ertt_pkg::TABLE_DEPTH; i++)
            if (live[i])
                slots.push_back(i);
        if (slots.size() == 0)
            return -1;
        return slots[$urandom_range(slots.size() - 1)];
    endfunction

    function automatic ertt_pkg::item_t reply_for(input int slot);
        return mk_item(ertt_pkg::OP_REPLY, live_id[slot], live_seqno[slot], live_peer[slot],
                       1'($urandom_range(1)), wall_tick);
    endfunction

    // One item of mixed traffic: well-formed register/reply pairs with random
    // content, plus corrupted replies, stray replies and the unused opcode.
    function automatic ertt_pkg::item_t traffic_item(input int reg_pct);
        ertt_pkg::item_t it;
        int              pick;
        int              slot;
        logic [63:0]     key;
        advance_tick();
        it   = mk_item(ertt_pkg::OP_REPLY, 16'($urandom), 16'($urandom), $urandom,
                       1'($urandom_range(1)), wall_tick);
        pick = $urandom_range(99);
        slot = pick_live_slot();
        if (pick < 3)
            it.opcode = ertt_pkg::OP_UNUSED;
        else if (pick < reg_pct)
        begin
            it.opcode = ($urandom_range(9) < 7) ? ertt_pkg::OP_REGISTER : ertt_pkg::OP_AUTO;
            // Now and then repeat an outstanding request to build duplicates.
            if (slot >= 0 && $urandom_range(9) == 0)
            begin
                it.request_id   = live_id[slot];
                it.sequence_req = live_seqno[slot];
                it.peer_addr    = live_peer[slot];
            end
        end
        else if (slot >= 0)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                it = reply_for(slot);
            else if (pick < 88)
            begin
                // Near miss: flip one bit of the id, sequence or peer.
                key = {live_id[slot], live_seqno[slot], live_peer[slot]};
                key = key ^ (64'd1 << $urandom_range(63));
                {it.request_id, it.sequence_req, it.peer_addr} = key;
            end
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one item, idling the sender at random first; on the transfer run the
    // predictor and queue what the tracker must return.
    task automatic offer_item(input ertt_pkg::item_t it, input row_check_t mode,
                              input ertt_pkg::result_t typed);
        ertt_pkg::result_t predicted;
        logic              has_result;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_ready !== 1'b1);
        has_result = predict_echo(it, predicted);
        if (mode == CHK_TYPED)
            pending_results.push_back(typed);
        else if (mode == CHK_MODEL && has_result)
            pending_results.push_back(predicted);
    endtask

    // Drop valid, wait for every expected result, then let an item that
    // produces nothing finish as well.
    task automatic settle_block();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_scale(input logic [7:0] value);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        scale_ms  = value;
    endtask

    // Answer outstanding requests in random order until the table is empty.
    task automatic drain_table();
        int slot;
        slot = pick_live_slot();
        while (slot >= 0)
        begin
            advance_tick();
            offer_item(reply_for(slot), CHK_MODEL, '0);
            slot = pick_live_slot();
        end
    endtask

    // Count only items that the tracker answers; the unused opcode rides along.
    task automatic run_traffic(input int count, input int reg_pct);
        ertt_pkg::item_t it;
        int              sent;
        sent = 0;
        while (sent < count)
        begin
            it = traffic_item(reg_pct);
            offer_item(it, CHK_MODEL, '0);
            if (it.opcode != ertt_pkg::OP_UNUSED)
                sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Drive result_ready: random idling, except for one long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            result_ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else
            result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, want %h", name, got, want));
    endtask

    // Compare each result transfer with the oldest expectation, field by field.
    always @(posedge clk)
    begin : result_checker
        ertt_pkg::result_t want;
        if (rst_n && result_valid === 1'b1 && result_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %h with nothing outstanding", result));
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(result.status), 32'(want.status));
                check_field("used_id", 32'(result.used_id), 32'(want.used_id));
                check_field("used_seq", 32'(result.used_seq), 32'(want.used_seq));
                check_field("round_trip", result.round_trip, want.round_trip);
                check_field("notify", 32'(result.notify), 32'(want.notify));
            end
        end
    end

    // Give up once nothing has moved on any channel for far too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready === 1'b1) || (result_valid === 1'b1 && result_ready) ||
                (cfg_valid && cfg_ready === 1'b1))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        stim_row_t         row;
        ertt_pkg::opcode_t op;

        for (int i = 0; i < ertt_pkg::TABLE_DEPTH; i++)
            live[i] = 1'b0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, run at the reset scale of 10 ms per tick. Typed results are
        // the ones that follow at a glance: empty table, extremes, wrapped ticks.
        add_row(CHK_TYPED, mk_item(ertt_pkg::OP_REPLY, 16'h0000, 16'h0000, 32'h0000_0000,
                                   1'b0, 32'd0),
                mk_result(ertt_pkg::ST_UNMATCHED, 16'h0000, 16'h0000, 32'd0, 1'b0));
        add_row(CHK_TYPED, mk_item(ertt_pkg::OP_REGISTER, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                   1'b1, 32'd0),
                mk_result(ertt_pkg::ST_REGISTERED, 16'hFFFF, 16'hFFFF, 32'd0, 1'b0));
        add_row(CHK_TYPED, mk_item(ertt_pkg::OP_AUTO, 16'h1234, 16'h5678, 32'h0000_0000,
                                   1'b0, 32'd100),
                mk_result(ertt_pkg::ST_REGISTERED, 16'd1, 16'd1, 32'd0, 1'b0));
        add_row(CHK_SILENT, mk_item(ertt_pkg::OP_UNUSED, 16'hAAAA, 16'h5555, 32'h1234_5678,
                                    1'b1, 32'd7),
                '0);
        add_row(CHK_TYPED, mk_item(ertt_pkg::OP_REPLY, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                   1'b0, 32'hFFFF_FFFF),
                mk_result(ertt_pkg::ST_MATCHED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF6, 1'b1));
        // Reply tick below the stored one: the difference wraps.
        add_row(CHK_TYPED, mk_item(ertt_pkg::OP_REPLY, 16'd1, 16'd1, 32'h0000_0000,
                                   1'b1, 32'd99),
                mk_result(ertt_pkg::ST_MATCHED, 16'd1, 16'd1, 32'hFFFF_FFF6, 1'b0));
        add_row(CHK_TYPED, mk_item(ertt_pkg::OP_AUTO, 16'h0000, 16'h0000, 32'hC0A8_0001,
                                   1'b1, 32'd1000),
                mk_result(ertt_pkg::ST_REGISTERED, 16'd2, 16'd1, 32'd0, 1'b0));
        add_row(CHK_TYPED, mk_item(ertt_pkg::OP_REPLY, 16'd2, 16'd1, 32'hC0A8_0001,
                                   1'b0, 32'd1003),
                mk_result(ertt_pkg::ST_MATCHED, 16'd2, 16'd1, 32'd30, 1'b1));
        // Duplicate requests: each reply frees only the lowest copy.
        add_row(CHK_MODEL, mk_item(ertt_pkg::OP_REGISTER, 16'd7, 16'd3, 32'h0A00_0001,
                                   1'b1, 32'd5), '0);
        add_row(CHK_MODEL, mk_item(ertt_pkg::OP_REGISTER, 16'd7, 16'd3, 32'h0A00_0001,
                                   1'b0, 32'd10), '0);
        add_row(CHK_MODEL, mk_item(ertt_pkg::OP_REPLY, 16'd7, 16'd3, 32'h0A00_0001,
                                   1'b0, 32'd20), '0);
        add_row(CHK_MODEL, mk_item(ertt_pkg::OP_REPLY, 16'd7, 16'd3, 32'h0A00_0001,
                                   1'b0, 32'd20), '0);
        add_row(CHK_MODEL, mk_item(ertt_pkg::OP_REPLY, 16'd7, 16'd3, 32'h0A00_0001,
                                   1'b0, 32'd20), '0);
        // Replies that miss on exactly one of peer, sequence or id, then the real one.
        add_row(CHK_MODEL, mk_item(ertt_pkg::OP_REGISTER, 16'd0, 16'd0, 32'd0, 1'b0,
                                   32'hFFFF_FFFF), '0);
        add_row(CHK_MODEL, mk_item(ertt_pkg::OP_REPLY, 16'd0, 16'd0, 32'd1, 1'b0, 32'd0), '0);
        add_row(CHK_MODEL, mk_item(ertt_pkg::OP_REPLY, 16'd0, 16'd1, 32'd0, 1'b0, 32'd0), '0);
        add_row(CHK_MODEL, mk_item(ertt_pkg::OP_REPLY, 16'd1, 16'd0, 32'd0, 1'b0, 32'd0), '0);
        add_row(CHK_MODEL, mk_item(ertt_pkg::OP_REPLY, 16'd0, 16'd0, 32'd0, 1'b1, 32'd0), '0);
        add_row(CHK_MODEL, mk_item(ertt_pkg::OP_REGISTER, 16'h8000, 16'h0001, 32'h8000_0000,
                                   1'b1, 32'h7FFF_FFFF), '0);
        add_row(CHK_MODEL, mk_item(ertt_pkg::OP_REPLY, 16'h8000, 16'h0001, 32'h8000_0000,
                                   1'b0, 32'h8000_0000), '0);
        add_row(CHK_SILENT, mk_item(ertt_pkg::OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                    1'b1, 32'hFFFF_FFFF), '0);

        for (int i = 0; i < directed_rows.size(); i++)
        begin
            row = directed_rows[i];
            offer_item(row.stim, row.mode, row.want);
        end

        // Fill the table at the top scale, overflow it with both register kinds,
        // then answer everything so products wrap.
        write_scale(8'd255);
        for (int n = 0; n < ertt_pkg::TABLE_DEPTH + 4; n++)
        begin
            advance_tick();
            if (n >= ertt_pkg::TABLE_DEPTH)
                op = (n % 2 == 0) ? ertt_pkg::OP_REGISTER : ertt_pkg::OP_AUTO;
            else
                op = ($urandom_range(1) == 0) ? ertt_pkg::OP_REGISTER : ertt_pkg::OP_AUTO;
            offer_item(mk_item(op, 16'($urandom), 16'($urandom), $urandom,
                               1'($urandom_range(1)), wall_tick),
                       CHK_MODEL, '0);
        end
        drain_table();

        // Mixed traffic at zero scale: sender rarely idles, receiver often does;
        // table fills up.
        write_scale(8'd0);
        run_traffic(300, 60);

        // Swap the idling sides.
        tx_idle_pct = 45;
        rx_idle_pct = 6;
        write_scale(8'd128);
        run_traffic(300, 45);

        // No idling, but start with a long receiver hold-off so the tracker backs up.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_scale(8'($urandom_range(1, 254)));
        hold_req <= 1'b1;
        run_traffic(300, 50);

        settle_block();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
